>>> rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned CountW   = 16;
   localparam int unsigned TrigW    = 8;
   localparam int unsigned DistW    = 12;
   localparam int unsigned ScaleW   = 12;
   localparam int unsigned ProdW    = CountW + ScaleW;
   localparam int unsigned FracW    = 16;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_TRIGGER_TICKS  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_TIMEOUT_TICKS  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DISTANCE_SCALE = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_NEAR_LIMIT     = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_MID_LIMIT      = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_FAR_LIMIT      = 3'd5;

   // zone codes
   localparam logic [1:0] ZONE_NEAR = 2'd0;
   localparam logic [1:0] ZONE_MID  = 2'd1;
   localparam logic [1:0] ZONE_FAR  = 2'd2;
   localparam logic [1:0] ZONE_NONE = 2'd3;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic             trigger_out;
      logic             busy_res;
      logic             done_res;
      logic             timed_out;
      logic [1:0]       zone;
      logic [DistW-1:0] distance_cm;
   } rsp_type;

   typedef struct packed {
      logic [TrigW-1:0]  trigger_ticks;
      logic [CountW-1:0] timeout_ticks;
      logic [ScaleW-1:0] distance_scale;
      logic [DistW-1:0]  near_limit;
      logic [DistW-1:0]  mid_limit;
      logic [DistW-1:0]  far_limit;
   } cfg_type;

   // one tick's outcome from the sequencer stage
   typedef struct packed {
      logic              trigger_out;
      logic              busy_res;
      logic              done_res;
      logic              timed_out;
      logic [CountW-1:0] echo_count;
   } tick_type;

endpackage

>>> rtl/uer_seq.sv
// Measurement sequencer: trigger, wait for echo, count echo width, timeout.
module uer_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  uer_pkg::req_type  req_word,
   input  uer_pkg::cfg_type  cfg,
   output uer_pkg::tick_type tick
);
   import uer_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} phase_type;

   phase_type         phase_ff, phase_in;
   logic [TrigW-1:0]  trig_cnt_ff, trig_cnt_in;
   logic [CountW-1:0] elapsed_ff, elapsed_in;
   logic [CountW-1:0] echo_cnt_ff, echo_cnt_in;
   tick_type          tick_ff, tick_in;

   function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
      sat_inc = (&v) ? v : v + 1'b1;
   endfunction

   // next state for one tick
   always_comb begin
      phase_in    = phase_ff;
      trig_cnt_in = trig_cnt_ff;
      elapsed_in  = elapsed_ff;
      echo_cnt_in = echo_cnt_ff;
      tick_in     = '0;

      if (phase_ff == PH_IDLE && req_word.start_req) begin
         phase_in    = PH_TRIG;
         trig_cnt_in = '0;
         elapsed_in  = '0;
         echo_cnt_in = '0;
      end

      if (phase_in != PH_IDLE) begin
         elapsed_in = sat_inc(elapsed_in);
         case (phase_in)
            PH_TRIG: begin
               tick_in.trigger_out = 1'b1;
               trig_cnt_in = trig_cnt_in + 1'b1;
               if (trig_cnt_in >= cfg.trigger_ticks) begin
                  phase_in = PH_WAIT;
               end
            end
            PH_WAIT: begin
               if (req_word.echo_level) begin
                  phase_in    = PH_MEAS;
                  echo_cnt_in = CountW'(1);
               end
            end
            PH_MEAS: begin
               if (req_word.echo_level) begin
                  echo_cnt_in = sat_inc(echo_cnt_in);
               end else begin
                  tick_in.done_res = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
         // fall on the timeout tick still counts as a completed echo
         if (phase_in != PH_IDLE && elapsed_in >= cfg.timeout_ticks) begin
            tick_in.timed_out = 1'b1;
            phase_in = PH_IDLE;
         end
      end

      tick_in.busy_res   = (phase_in != PH_IDLE);
      tick_in.echo_count = echo_cnt_in;
   end

   // state and stage register, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         trig_cnt_ff <= '0;
         elapsed_ff  <= '0;
         echo_cnt_ff <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         trig_cnt_ff <= trig_cnt_in;
         elapsed_ff  <= elapsed_in;
         echo_cnt_ff <= echo_cnt_in;
      end
      if (take) begin
         tick_ff <= tick_in;
      end
   end

   assign tick = tick_ff;

endmodule

>>> rtl/uer_range.sv
// Distance scaling and zone classification, two register stages.
module uer_range (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_mul,
   input  logic              load_out,
   input  uer_pkg::tick_type tick,
   input  uer_pkg::cfg_type  cfg,
   output uer_pkg::rsp_type  rsp_word
);
   import uer_pkg::*;

   logic [ProdW-1:0] prod_ff;
   logic             trig_ff, busy_ff, done_ff, tout_ff;
   logic [DistW-1:0] last_dist_ff;
   logic [1:0]       last_zone_ff;
   logic [DistW-1:0] dist_cm;
   logic [1:0]       zone;
   rsp_type          rsp_ff, rsp_in;

   // product fits 28 bits, so the integer part never exceeds 4095
   assign dist_cm = prod_ff[FracW +: DistW];

   // thresholds applied in order near, mid, far
   always_comb begin
      if (dist_cm < cfg.near_limit) begin
         zone = ZONE_NEAR;
      end else if (dist_cm < cfg.mid_limit) begin
         zone = ZONE_MID;
      end else if (dist_cm < cfg.far_limit) begin
         zone = ZONE_FAR;
      end else begin
         zone = ZONE_NONE;
      end
      rsp_in.trigger_out = trig_ff;
      rsp_in.busy_res    = busy_ff;
      rsp_in.done_res    = done_ff;
      rsp_in.timed_out   = tout_ff;
      rsp_in.zone        = done_ff ? zone : last_zone_ff;
      rsp_in.distance_cm = done_ff ? dist_cm : last_dist_ff;
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (load_mul) begin
         prod_ff <= ProdW'(tick.echo_count) * ProdW'(cfg.distance_scale);
         trig_ff <= tick.trigger_out;
         busy_ff <= tick.busy_res;
         done_ff <= tick.done_res;
         tout_ff <= tick.timed_out;
      end
   end

   // result stage and held last measurement
   always_ff @(posedge clock) begin
      if (reset) begin
         last_dist_ff <= '0;
         last_zone_ff <= ZONE_NONE;
      end else if (load_out && done_ff) begin
         last_dist_ff <= dist_cm;
         last_zone_ff <= zone;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: config registers and pipeline control.
//
// Each word on the req channel is one 1 us tick: a start request and the
// sampled echo level. Each accepted req word yields exactly one rsp word
// with the trigger level, busy flag, done and timeout pulses, and the last
// zone and distance in cm. Words must be sent every tick to keep time.
// An accepted req word passes the sequencer stage, the multiply stage
// (16x12 echo count times scale), then zone compare into the result
// register, which drives rsp_valid. Throughput is one word per cycle; the
// stages only hold a word when the next one is still occupied, so a
// stalled rsp side fills at most three words before req_ready drops.
// The csr port takes a register index and data; it is always ready and
// should be written only while no measurement is pending. Unknown indexes
// are dropped.
// Synchronous reset returns the sequencer to idle, loads the default
// register values, sets the last zone to none and distance to zero, and
// empties the pipeline.
module ultrasonic_echo_ranger (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  uer_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output uer_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uer_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [uer_pkg::CsrDataW-1:0]      csr_data
);
   import uer_pkg::*;

   cfg_type  cfg_ff;
   logic     seq_v_ff, mul_v_ff, out_v_ff;
   logic     out_free, mul_free, seq_free;
   logic     take, load_mul, load_out;
   tick_type tick;

   // csr writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks  <= TrigW'(10);
         cfg_ff.timeout_ticks  <= CountW'(30000);
         cfg_ff.distance_scale <= ScaleW'(1114);
         cfg_ff.near_limit     <= DistW'(100);
         cfg_ff.mid_limit      <= DistW'(200);
         cfg_ff.far_limit      <= DistW'(300);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRIGGER_TICKS:  cfg_ff.trigger_ticks  <= csr_data[TrigW-1:0];
            CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr_data[CountW-1:0];
            CSR_DISTANCE_SCALE: cfg_ff.distance_scale <= csr_data[ScaleW-1:0];
            CSR_NEAR_LIMIT:     cfg_ff.near_limit     <= csr_data[DistW-1:0];
            CSR_MID_LIMIT:      cfg_ff.mid_limit      <= csr_data[DistW-1:0];
            CSR_FAR_LIMIT:      cfg_ff.far_limit      <= csr_data[DistW-1:0];
            default: ;
         endcase
      end
   end

   // stage advance: a stage loads when it is empty or its word moves on
   assign out_free  = !out_v_ff || rsp_ready;
   assign mul_free  = !mul_v_ff || out_free;
   assign seq_free  = !seq_v_ff || mul_free;
   assign req_ready = seq_free;
   assign take      = req_valid && req_ready;
   assign load_mul  = seq_v_ff && mul_free;
   assign load_out  = mul_v_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (seq_free) begin
            seq_v_ff <= take;
         end
         if (mul_free) begin
            mul_v_ff <= seq_v_ff;
         end
         if (out_free) begin
            out_v_ff <= mul_v_ff;
         end
      end
   end

   uer_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_word (req_data),
      .cfg      (cfg_ff),
      .tick     (tick)
   );

   uer_range u_range (
      .clock    (clock),
      .reset    (reset),
      .load_mul (load_mul),
      .load_out (load_out),
      .tick     (tick),
      .cfg      (cfg_ff),
      .rsp_word (rsp_data)
   );

   assign rsp_valid = out_v_ff;

   // done and timeout are exclusive outcomes
   a_done_tout_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.timed_out))
      else $error("done and timeout in one word");

   // a finished measurement leaves the block idle
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("busy after done");

   a_tout_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.timed_out) |-> !rsp_data.busy_res)
      else $error("busy after timeout");

   // an empty result stage never blocks the input
   a_empty_ready : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result stage");

endmodule
